FILE: rtl/core/i2cmbe_pkg.sv
package i2cmbe_pkg;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned DATA_W   = 8;
   localparam int unsigned TICK_W   = 16;
   localparam int unsigned BIDX_W   = 4;

   localparam logic [TICK_W-1:0] HALF_PERIOD_RESET = 16'd1000;

   // bit counts per command: stop is a single bit, a byte plus ack slot is nine
   localparam logic [BIDX_W-1:0] BITS_STOP  = 4'd1;
   localparam logic [BIDX_W-1:0] BITS_BYTE  = 4'd9;
   localparam logic [BIDX_W-1:0] DATA_BITS  = 4'd8;

   typedef enum logic [KIND_W-1:0] {
      CMD_NONE  = 3'd0,
      CMD_START = 3'd1,
      CMD_STOP  = 3'd2,
      CMD_WRITE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

endpackage

FILE: rtl/core/i2cmbe_req_if.sv
interface i2cmbe_req_if;
   logic                            valid;
   logic                            ready;
   logic [i2cmbe_pkg::KIND_W-1:0]   kind;
   logic [i2cmbe_pkg::DATA_W-1:0]   data_byte;
   logic                            ack_wanted;
   logic                            sda_sample;

   modport source (output valid, kind, data_byte, ack_wanted, sda_sample, input ready);
   modport sink   (input valid, kind, data_byte, ack_wanted, sda_sample, output ready);
endinterface

FILE: rtl/core/i2cmbe_rsp_if.sv
interface i2cmbe_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            scl_release;
   logic                            sda_release;
   logic                            busy_res;
   logic                            done_res;
   logic [i2cmbe_pkg::DATA_W-1:0]   read_byte;

   modport source (output valid, scl_release, sda_release, busy_res, done_res, read_byte,
                   input ready);
   modport sink   (input valid, scl_release, sda_release, busy_res, done_res, read_byte,
                   output ready);
endinterface

FILE: rtl/core/i2c_master_byte_engine_unit.sv
// The rsp word for an accepted req word appears in the cycle after acceptance.
// One req word per cycle when ready; each word is one bus timing tick, and the
// tick's sequencer update plus the output register form a single stage.
// Ready drops only while a finished rsp word waits and rsp ready is low.
// Synchronous active-high reset: idle, SCL and SDA released, half period 1000.
module i2c_master_byte_engine_unit (
   input  logic                              clock,
   input  logic                              reset,
   i2cmbe_req_if.sink                        req_chan,
   i2cmbe_rsp_if.source                      rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [i2cmbe_pkg::TICK_W-1:0]     csr_wr_data
);

   localparam int unsigned DW = i2cmbe_pkg::DATA_W;
   localparam int unsigned TW = i2cmbe_pkg::TICK_W;
   localparam int unsigned BW = i2cmbe_pkg::BIDX_W;

   // sequencer state
   i2cmbe_pkg::cmd_type cmd_ff, cmd_in;
   logic [BW-1:0]       bidx_ff, bidx_in;
   logic [DW-1:0]       shift_ff, shift_in;
   logic                ack_drive_ff, ack_drive_in;
   logic                high_half_ff, high_half_in;
   logic [TW-1:0]       tick_ff, tick_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic [TW-1:0]       half_ff;

   // output register
   logic                rsp_valid_ff;
   logic                scl_out_ff, scl_out_in;
   logic                sda_out_ff, sda_out_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DW-1:0]       rbyte_ff, rbyte_in;

   logic [TW-1:0]       half_eff;
   logic [TW-1:0]       tick_inc;
   logic [BW-1:0]       total_bits;
   logic                bit_lvl;
   logic                accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign half_eff = (half_ff == '0) ? TW'(1) : half_ff;

   always_comb begin
      cmd_in       = cmd_ff;
      bidx_in      = bidx_ff;
      shift_in     = shift_ff;
      ack_drive_in = ack_drive_ff;
      high_half_in = high_half_ff;
      tick_in      = tick_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      done_in      = 1'b0;
      rbyte_in     = '0;
      tick_inc     = '0;
      total_bits   = i2cmbe_pkg::BITS_BYTE;
      bit_lvl      = 1'b1;

      if (cmd_ff == i2cmbe_pkg::CMD_NONE) begin
         if (req_chan.kind == i2cmbe_pkg::CMD_START) begin
            sda_in  = 1'b0;
            done_in = 1'b1;
         end else if (req_chan.kind == i2cmbe_pkg::CMD_STOP ||
                      req_chan.kind == i2cmbe_pkg::CMD_WRITE ||
                      req_chan.kind == i2cmbe_pkg::CMD_READ) begin
            cmd_in       = i2cmbe_pkg::cmd_type'(req_chan.kind);
            bidx_in      = '0;
            shift_in     = (req_chan.kind == i2cmbe_pkg::CMD_WRITE) ? req_chan.data_byte : '0;
            ack_drive_in = (req_chan.kind == i2cmbe_pkg::CMD_READ) && req_chan.ack_wanted;
            scl_in       = 1'b0;
            high_half_in = 1'b0;
            tick_in      = '0;
         end
      end

      // bus levels shown for this tick are those after a command launch
      scl_out_in = scl_in;
      sda_out_in = sda_in;

      // SDA level for the current bit
      if (cmd_in == i2cmbe_pkg::CMD_STOP) begin
         bit_lvl = 1'b0;
      end else if (bidx_in >= i2cmbe_pkg::DATA_BITS) begin
         bit_lvl = (cmd_in == i2cmbe_pkg::CMD_READ) ? !ack_drive_in : 1'b1;
      end else if (cmd_in == i2cmbe_pkg::CMD_WRITE) begin
         bit_lvl = shift_in[3'd7 - bidx_in[2:0]];
      end

      total_bits = (cmd_in == i2cmbe_pkg::CMD_STOP) ? i2cmbe_pkg::BITS_STOP
                                                    : i2cmbe_pkg::BITS_BYTE;

      if (cmd_in != i2cmbe_pkg::CMD_NONE) begin
         tick_inc = tick_in + TW'(1);
         if (tick_inc >= half_eff) begin
            tick_in = '0;
            if (!high_half_in) begin
               sda_in       = bit_lvl;
               scl_in       = 1'b1;
               high_half_in = 1'b1;
            end else begin
               if (cmd_in == i2cmbe_pkg::CMD_READ && bidx_in < i2cmbe_pkg::DATA_BITS) begin
                  shift_in = {shift_in[DW-2:0], req_chan.sda_sample};
               end
               bidx_in = bidx_in + BW'(1);
               if (bidx_in >= total_bits) begin
                  if (cmd_in == i2cmbe_pkg::CMD_STOP) begin
                     sda_in = 1'b1;
                  end
                  if (cmd_in == i2cmbe_pkg::CMD_READ) begin
                     rbyte_in = shift_in;
                  end
                  done_in = 1'b1;
                  cmd_in  = i2cmbe_pkg::CMD_NONE;
               end else begin
                  scl_in       = 1'b0;
                  high_half_in = 1'b0;
               end
            end
         end else begin
            tick_in = tick_inc;
         end
      end

      busy_in = (cmd_in != i2cmbe_pkg::CMD_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff       <= i2cmbe_pkg::CMD_NONE;
         bidx_ff      <= '0;
         shift_ff     <= '0;
         ack_drive_ff <= 1'b0;
         high_half_ff <= 1'b1;
         tick_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
      end else if (accept) begin
         cmd_ff       <= cmd_in;
         bidx_ff      <= bidx_in;
         shift_ff     <= shift_in;
         ack_drive_ff <= ack_drive_in;
         high_half_ff <= high_half_in;
         tick_ff      <= tick_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= i2cmbe_pkg::HALF_PERIOD_RESET;
      end else if (csr_wr_en) begin
         half_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         scl_out_ff <= scl_out_in;
         sda_out_ff <= sda_out_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         rbyte_ff   <= rbyte_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.scl_release = scl_out_ff;
   assign rsp_chan.sda_release = sda_out_ff;
   assign rsp_chan.busy_res    = busy_ff;
   assign rsp_chan.done_res    = done_ff;
   assign rsp_chan.read_byte   = rbyte_ff;

endmodule

FILE: rtl/core/i2cmbe_checker.sv
module i2cmbe_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_scl_release,
   input logic                            rsp_sda_release,
   input logic                            rsp_busy_res,
   input logic                            rsp_done_res,
   input logic [i2cmbe_pkg::DATA_W-1:0]   rsp_read_byte
);

   // every accepted tick yields a word on the next cycle
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted word produced no rsp word");

   // back pressure only while an unread word is stalled
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req ready low without a stalled rsp word");

   // a completing command leaves the engine idle
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done and busy together");

   // read data appears only on completion
   a_rbyte_on_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_byte != '0 |-> rsp_done_res)
      else $error("read byte without done");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scl_release) &&
         $stable(rsp_sda_release) && $stable(rsp_busy_res) &&
         $stable(rsp_done_res) && $stable(rsp_read_byte))
      else $error("stalled rsp word changed");

endmodule

bind i2c_master_byte_engine_unit i2cmbe_checker u_i2cmbe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_scl_release (rsp_chan.scl_release),
   .rsp_sda_release (rsp_chan.sda_release),
   .rsp_busy_res    (rsp_chan.busy_res),
   .rsp_done_res    (rsp_chan.done_res),
   .rsp_read_byte   (rsp_chan.read_byte)
);
